@@ rtl/core/hlm_pkg.sv @@
// Shared types, codes and constants of the heartbeat liveness monitor.
package hlm_pkg;

  localparam int SLOTS_DEFAULT     = 32;
  localparam logic [31:0] LOCAL_ID_RESET  = 32'd1;
  localparam logic [31:0] THRESHOLD_RESET = 32'd5000;
  localparam logic [31:0] COORD_RESET     = 32'd1;
  localparam logic [4:0]  MAX_EVENTS      = 5'd31;

  typedef enum logic [2:0] {
    CMD_INIT      = 3'd0,
    CMD_HEARTBEAT = 3'd1,
    CMD_TICK      = 3'd2,
    CMD_REGISTER  = 3'd3,
    CMD_ALIVE     = 3'd4
  } hlm_cmd_t;

  typedef enum logic [2:0] {
    KIND_INIT_DONE = 3'd0,
    KIND_HB_ACK    = 3'd1,
    KIND_FAILURE   = 3'd2,
    KIND_TICK_DONE = 3'd3,
    KIND_REG_REPLY = 3'd4,
    KIND_ALIVE     = 3'd5
  } hlm_kind_t;

  typedef enum logic {
    REG_LOCAL_ID  = 1'b0,
    REG_THRESHOLD = 1'b1
  } hlm_reg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_HB_MAX, S_FIND_RD, S_FIND_EV, S_FIND_END,
    S_TK_START, S_TK_RD, S_TK_SELF, S_TK_AGE, S_TK_CMP, S_TK_COORD,
    S_EL_RD, S_EL_EV, S_EL_END, S_TK_EVENT, S_TK_DONE
  } hlm_state_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] node_id;
    logic [31:0] timestamp;
  } hlm_req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] event_node;
    logic [4:0]  slot;
    logic        slot_found;
    logic        recovered;
    logic        alive;
    logic [31:0] coordinator;
    logic [4:0]  failure_count;
    logic        not_ready;
    logic        election_error;
    logic        announce;
    logic        last;
  } hlm_res_t;

  typedef struct packed {
    logic rd_en;
    logic wr_node;
    logic wr_seen;
  } hlm_mem_ctl_t;

  typedef struct packed {
    logic        eq;
    logic        gt;
    logic [31:0] diff;
  } hlm_alu_out_t;

endpackage

@@ rtl/core/hlm_alu.sv @@
// Shared 32-bit subtractor giving difference, equal and greater-than flags.
module hlm_alu (
  input  logic [31:0]          a,
  input  logic [31:0]          b,
  output hlm_pkg::hlm_alu_out_t flags
);

  logic [32:0] sub;

  // Subtract once; borrow and zero give the compares
  assign sub        = {1'b0, a} - {1'b0, b};
  assign flags.diff = sub[31:0];
  assign flags.eq   = (sub[31:0] == 32'd0);
  assign flags.gt   = !sub[32] && (sub[31:0] != 32'd0);

endmodule

@@ rtl/core/hlm_table.sv @@
// Slot table memory: node id and last-seen time, one read and one write port.
module hlm_table #(
  parameter int SLOTS = hlm_pkg::SLOTS_DEFAULT,
  localparam int IW = $clog2(SLOTS)
) (
  input  logic                 clk,
  input  hlm_pkg::hlm_mem_ctl_t ctl,
  input  logic [IW-1:0]        rd_addr,
  input  logic [IW-1:0]        wr_addr,
  input  logic [31:0]          wr_node_data,
  input  logic [31:0]          wr_seen_data,
  output logic [31:0]          rd_node,
  output logic [31:0]          rd_seen
);

  logic [31:0] node_mem [SLOTS];
  logic [31:0] seen_mem [SLOTS];

  // Write either column at the write address
  always_ff @(posedge clk) begin
    if (ctl.wr_node) begin
      node_mem[wr_addr] <= wr_node_data;
    end
    if (ctl.wr_seen) begin
      seen_mem[wr_addr] <= wr_seen_data;
    end
  end

  // Register read data; hold it between reads
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_node <= node_mem[rd_addr];
      rd_seen <= seen_mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/hlm_seq.sv @@
// Command sequencer: slot scans, timeout checks and election over the table.
module hlm_seq #(
  parameter int SLOTS = hlm_pkg::SLOTS_DEFAULT,
  localparam int IW = $clog2(SLOTS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  hlm_pkg::hlm_req_t     request,
  output logic                  busy,
  output logic                  done,
  output hlm_pkg::hlm_res_t     result,
  input  logic [31:0]           local_id,
  input  logic [31:0]           threshold,
  output hlm_pkg::hlm_mem_ctl_t mem_ctl,
  output logic [IW-1:0]         rd_addr,
  output logic [IW-1:0]         wr_addr,
  output logic [31:0]           wr_node_data,
  output logic [31:0]           wr_seen_data,
  input  logic [31:0]           rd_node,
  input  logic [31:0]           rd_seen
);

  localparam logic [IW:0] SlotEnd = (IW+1)'(SLOTS);

  hlm_pkg::hlm_state_t state, state_next;
  logic [IW:0]        idx, idx_next, eidx, eidx_next;
  logic [2:0]         cmd_r, cmd_r_next;
  logic [31:0]        id_r, id_r_next, ts_r, ts_r_next;
  logic [31:0]        clock_now, clock_now_next, coord, coord_next;
  logic               ready, ready_next;
  logic [SLOTS-1:0]   active, active_next, failed, failed_next;
  logic               found, found_next, free_ok, free_ok_next;
  logic [IW-1:0]      found_idx, found_idx_next, free_idx, free_idx_next;
  logic [31:0]        cur_node, cur_node_next, age, age_next, best, best_next;
  logic [4:0]         count, count_next;
  logic               err, err_next, ann, ann_next;
  hlm_pkg::hlm_res_t  res_next;
  logic               done_next;
  logic [31:0]        alu_a, alu_b;
  hlm_pkg::hlm_alu_out_t alu;
  logic [IW-1:0]      i, j;

  assign i    = idx[IW-1:0];
  assign j    = eidx[IW-1:0];
  assign busy = (state != hlm_pkg::S_IDLE);

  hlm_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .flags (alu)
  );

  // Hold state and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hlm_pkg::S_IDLE;
      clock_now <= 32'd0;
      coord     <= hlm_pkg::COORD_RESET;
      ready     <= 1'b0;
      active    <= '0;
      failed    <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      clock_now <= clock_now_next;
      coord     <= coord_next;
      ready     <= ready_next;
      active    <= active_next;
      failed    <= failed_next;
      done      <= done_next;
    end
  end

  // Hold working payload
  always_ff @(posedge clk) begin
    idx       <= idx_next;
    eidx      <= eidx_next;
    cmd_r     <= cmd_r_next;
    id_r      <= id_r_next;
    ts_r      <= ts_r_next;
    found     <= found_next;
    found_idx <= found_idx_next;
    free_ok   <= free_ok_next;
    free_idx  <= free_idx_next;
    cur_node  <= cur_node_next;
    age       <= age_next;
    best      <= best_next;
    count     <= count_next;
    err       <= err_next;
    ann       <= ann_next;
    result    <= res_next;
  end

  // Next state, unit operands, table access and results
  always_comb begin
    state_next     = state;
    idx_next       = idx;
    eidx_next      = eidx;
    cmd_r_next     = cmd_r;
    id_r_next      = id_r;
    ts_r_next      = ts_r;
    clock_now_next = clock_now;
    coord_next     = coord;
    ready_next     = ready;
    active_next    = active;
    failed_next    = failed;
    found_next     = found;
    found_idx_next = found_idx;
    free_ok_next   = free_ok;
    free_idx_next  = free_idx;
    cur_node_next  = cur_node;
    age_next       = age;
    best_next      = best;
    count_next     = count;
    err_next       = err;
    ann_next       = ann;
    res_next       = result;
    done_next      = 1'b0;
    alu_a          = 32'd0;
    alu_b          = 32'd0;
    mem_ctl        = '0;
    rd_addr        = i;
    wr_addr        = i;
    wr_node_data   = id_r;
    wr_seen_data   = clock_now;

    case (state)
      hlm_pkg::S_IDLE: begin
        if (start) begin
          cmd_r_next    = request.cmd;
          id_r_next     = request.node_id;
          ts_r_next     = request.timestamp;
          idx_next      = '0;
          found_next    = 1'b0;
          free_ok_next  = 1'b0;
          res_next      = '0;
          res_next.event_node = request.node_id;
          res_next.last = 1'b1;
          case (request.cmd)
            hlm_pkg::CMD_INIT: begin
              coord_next     = local_id;
              clock_now_next = 32'd0;
              active_next    = '0;
              active_next[0] = 1'b1;
              failed_next    = '0;
              ready_next     = 1'b1;
              mem_ctl.wr_node = 1'b1;
              mem_ctl.wr_seen = 1'b1;
              wr_addr        = '0;
              wr_node_data   = local_id;
              wr_seen_data   = 32'd0;
              res_next.kind       = hlm_pkg::KIND_INIT_DONE;
              res_next.slot_found = 1'b1;
              done_next      = 1'b1;
            end
            hlm_pkg::CMD_HEARTBEAT: begin
              state_next = hlm_pkg::S_HB_MAX;
            end
            hlm_pkg::CMD_TICK: begin
              if (ready) begin
                state_next = hlm_pkg::S_TK_START;
              end else begin
                res_next.kind      = hlm_pkg::KIND_TICK_DONE;
                res_next.not_ready = 1'b1;
                done_next          = 1'b1;
              end
            end
            hlm_pkg::CMD_REGISTER, hlm_pkg::CMD_ALIVE: begin
              state_next = hlm_pkg::S_FIND_RD;
            end
            default: begin
            end
          endcase
        end
      end

      // Raise the clock to the sender's timestamp
      hlm_pkg::S_HB_MAX: begin
        alu_a = ts_r;
        alu_b = clock_now;
        if (alu.gt) begin
          clock_now_next = ts_r;
        end
        state_next = hlm_pkg::S_FIND_RD;
      end

      // Walk the slots for the node; note the first free slot on the way
      hlm_pkg::S_FIND_RD: begin
        if (idx == SlotEnd) begin
          state_next = hlm_pkg::S_FIND_END;
        end else if (!active[i]) begin
          if (!free_ok) begin
            free_ok_next  = 1'b1;
            free_idx_next = i;
          end
          idx_next = idx + 1'b1;
        end else begin
          mem_ctl.rd_en = 1'b1;
          state_next    = hlm_pkg::S_FIND_EV;
        end
      end

      hlm_pkg::S_FIND_EV: begin
        alu_a = rd_node;
        alu_b = id_r;
        if (alu.eq) begin
          found_next     = 1'b1;
          found_idx_next = i;
          state_next     = hlm_pkg::S_FIND_END;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = hlm_pkg::S_FIND_RD;
        end
      end

      // Refresh, take a slot or answer the query
      hlm_pkg::S_FIND_END: begin
        res_next.slot_found = 1'b0;
        res_next.slot       = 5'd0;
        if (cmd_r == hlm_pkg::CMD_ALIVE) begin
          res_next.kind  = hlm_pkg::KIND_ALIVE;
          res_next.alive = found && !failed[found_idx];
        end else begin
          res_next.kind = (cmd_r == hlm_pkg::CMD_HEARTBEAT) ?
                          hlm_pkg::KIND_HB_ACK : hlm_pkg::KIND_REG_REPLY;
          if (found) begin
            res_next.slot       = 5'(found_idx);
            res_next.slot_found = 1'b1;
            if (cmd_r == hlm_pkg::CMD_HEARTBEAT) begin
              wr_addr         = found_idx;
              mem_ctl.wr_seen = 1'b1;
              if (failed[found_idx]) begin
                failed_next[found_idx] = 1'b0;
                res_next.recovered     = 1'b1;
              end
            end
          end else if (free_ok) begin
            wr_addr                = free_idx;
            mem_ctl.wr_node        = 1'b1;
            mem_ctl.wr_seen        = 1'b1;
            active_next[free_idx]  = 1'b1;
            failed_next[free_idx]  = 1'b0;
            res_next.slot          = 5'(free_idx);
            res_next.slot_found    = 1'b1;
          end
        end
        done_next  = 1'b1;
        state_next = hlm_pkg::S_IDLE;
      end

      // Advance the clock by one: subtracting all ones adds one
      hlm_pkg::S_TK_START: begin
        alu_a          = clock_now;
        alu_b          = '1;
        clock_now_next = alu.diff;
        count_next     = 5'd0;
        state_next     = hlm_pkg::S_TK_RD;
      end

      hlm_pkg::S_TK_RD: begin
        if (idx == SlotEnd) begin
          state_next = hlm_pkg::S_TK_DONE;
        end else if (!active[i] || failed[i]) begin
          idx_next = idx + 1'b1;
        end else begin
          mem_ctl.rd_en = 1'b1;
          state_next    = hlm_pkg::S_TK_SELF;
        end
      end

      // Skip the local node
      hlm_pkg::S_TK_SELF: begin
        alu_a         = rd_node;
        alu_b         = local_id;
        cur_node_next = rd_node;
        if (alu.eq) begin
          idx_next   = idx + 1'b1;
          state_next = hlm_pkg::S_TK_RD;
        end else begin
          state_next = hlm_pkg::S_TK_AGE;
        end
      end

      hlm_pkg::S_TK_AGE: begin
        alu_a      = clock_now;
        alu_b      = rd_seen;
        age_next   = alu.diff;
        state_next = hlm_pkg::S_TK_CMP;
      end

      // Mark the peer failed when its silence passes the threshold
      hlm_pkg::S_TK_CMP: begin
        alu_a = age;
        alu_b = threshold;
        if (alu.gt) begin
          failed_next[i] = 1'b1;
          count_next     = count + 1'b1;
          err_next       = 1'b0;
          ann_next       = 1'b0;
          state_next     = hlm_pkg::S_TK_COORD;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = hlm_pkg::S_TK_RD;
        end
      end

      hlm_pkg::S_TK_COORD: begin
        alu_a = cur_node;
        alu_b = coord;
        if (alu.eq) begin
          eidx_next  = '0;
          best_next  = 32'd0;
          state_next = hlm_pkg::S_EL_RD;
        end else begin
          state_next = hlm_pkg::S_TK_EVENT;
        end
      end

      // Election: highest id among live slots
      hlm_pkg::S_EL_RD: begin
        rd_addr = j;
        if (eidx == SlotEnd) begin
          state_next = hlm_pkg::S_EL_END;
        end else if (!active[j] || failed[j]) begin
          eidx_next = eidx + 1'b1;
        end else begin
          mem_ctl.rd_en = 1'b1;
          state_next    = hlm_pkg::S_EL_EV;
        end
      end

      hlm_pkg::S_EL_EV: begin
        alu_a = rd_node;
        alu_b = best;
        if (alu.gt) begin
          best_next = rd_node;
        end
        eidx_next  = eidx + 1'b1;
        state_next = hlm_pkg::S_EL_RD;
      end

      hlm_pkg::S_EL_END: begin
        alu_a = best;
        alu_b = local_id;
        if (best == 32'd0) begin
          err_next = 1'b1;
        end else begin
          coord_next = best;
          ann_next   = alu.eq;
        end
        state_next = hlm_pkg::S_TK_EVENT;
      end

      // Report the failure; stop after the event limit
      hlm_pkg::S_TK_EVENT: begin
        res_next                = '0;
        res_next.kind           = hlm_pkg::KIND_FAILURE;
        res_next.event_node     = cur_node;
        res_next.slot           = 5'(i);
        res_next.slot_found     = 1'b1;
        res_next.election_error = err;
        res_next.announce       = ann;
        done_next               = 1'b1;
        if (count == hlm_pkg::MAX_EVENTS) begin
          state_next = hlm_pkg::S_TK_DONE;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = hlm_pkg::S_TK_RD;
        end
      end

      hlm_pkg::S_TK_DONE: begin
        res_next               = '0;
        res_next.kind          = hlm_pkg::KIND_TICK_DONE;
        res_next.event_node    = id_r;
        res_next.failure_count = count;
        res_next.last          = 1'b1;
        done_next              = 1'b1;
        state_next             = hlm_pkg::S_IDLE;
      end

      default: begin
        state_next = hlm_pkg::S_IDLE;
      end
    endcase

    if (done_next) begin
      res_next.coordinator = coord_next;
    end
  end

endmodule

@@ rtl/core/heartbeat_liveness_monitor.sv @@
// Top level: configuration registers, sequencer and slot table.
//
// Commands enter on start while busy is low; each result shows on result for
// one cycle with done high and cannot be held off, and the final result of a
// command has last set. Init, and a tick refused before init, answer in the
// cycle after start. Heartbeat, register and alive query walk the slots,
// reading the table only at active slots and stopping at the node's slot. A
// tick walks the slots and checks each live peer's age against the threshold,
// and each coordinator failure adds an election walk over the slots; all
// walks share one subtractor and the single read port of the slot table. The
// table needs no clearing pass after reset: active and failed flags live in
// flip-flops.
module heartbeat_liveness_monitor #(
  parameter int SLOTS = hlm_pkg::SLOTS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  hlm_pkg::hlm_req_t request,
  output logic              busy,
  output logic              done,
  output hlm_pkg::hlm_res_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int IW = $clog2(SLOTS);

  logic [31:0]           local_id, threshold;
  hlm_pkg::hlm_mem_ctl_t mem_ctl;
  logic [IW-1:0]         rd_addr, wr_addr;
  logic [31:0]           wr_node_data, wr_seen_data, rd_node, rd_seen;
  logic                  cfg_wr;
  hlm_pkg::hlm_reg_t     reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = hlm_pkg::hlm_reg_t'(paddr[2]);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      local_id  <= hlm_pkg::LOCAL_ID_RESET;
      threshold <= hlm_pkg::THRESHOLD_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        hlm_pkg::REG_LOCAL_ID:  local_id  <= pwdata;
        hlm_pkg::REG_THRESHOLD: threshold <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    case (reg_sel)
      hlm_pkg::REG_LOCAL_ID:  prdata = local_id;
      hlm_pkg::REG_THRESHOLD: prdata = threshold;
      default:                prdata = 32'd0;
    endcase
  end

  hlm_seq #(.SLOTS(SLOTS)) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .request      (request),
    .busy         (busy),
    .done         (done),
    .result       (result),
    .local_id     (local_id),
    .threshold    (threshold),
    .mem_ctl      (mem_ctl),
    .rd_addr      (rd_addr),
    .wr_addr      (wr_addr),
    .wr_node_data (wr_node_data),
    .wr_seen_data (wr_seen_data),
    .rd_node      (rd_node),
    .rd_seen      (rd_seen)
  );

  hlm_table #(.SLOTS(SLOTS)) u_table (
    .clk          (clk),
    .ctl          (mem_ctl),
    .rd_addr      (rd_addr),
    .wr_addr      (wr_addr),
    .wr_node_data (wr_node_data),
    .wr_seen_data (wr_seen_data),
    .rd_node      (rd_node),
    .rd_seen      (rd_seen)
  );

endmodule

@@ rtl/core/hlm_checker.sv @@
// Port checker for the heartbeat liveness monitor, bound to the top level.
module hlm_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input hlm_pkg::hlm_res_t result
);

  // Final result frees the block at once
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    done && result.last |-> !busy)
    else $error("busy after final result");

  // A result that is not final leaves the block working
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    done && !result.last |-> busy)
    else $error("idle after non-final result");

  // Failure events never close a command
  a_fail_not_last: assert property (@(posedge clk) disable iff (rst)
    done && result.kind == hlm_pkg::KIND_FAILURE |-> !result.last)
    else $error("failure event marked last");

  // Refusal only on tick done
  a_not_ready_tick: assert property (@(posedge clk) disable iff (rst)
    done && result.not_ready |-> result.kind == hlm_pkg::KIND_TICK_DONE)
    else $error("not_ready on wrong result");

  // No result without a request in flight
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) || $past(start))
    else $error("result without request");

endmodule

bind heartbeat_liveness_monitor hlm_checker u_hlm_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
